// ----- sv/tte_pkg.sv -----
// Package for the TCP timer expiry action block.
// Holds the transfer structs, codes, register indexes and the backoff table.
// Has no dependencies.
package tte_pkg;

    localparam int MAX_SHIFT = 12;
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS = 4;

    localparam logic [1:0] KIND_RETX = 2'd0;
    localparam logic [1:0] KIND_PERSIST = 2'd1;
    localparam logic [1:0] KIND_KEEP = 2'd2;
    localparam logic [1:0] KIND_2MSL = 2'd3;

    localparam logic [3:0] ST_ESTABLISHED = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT_2 = 4'd9;
    localparam logic [3:0] ST_TIME_WAIT = 4'd10;

    localparam logic [2:0] ACT_REARM = 3'd0;
    localparam logic [2:0] ACT_CLOSE = 3'd1;
    localparam logic [2:0] ACT_DROP = 3'd2;
    localparam logic [2:0] ACT_RETX = 3'd3;
    localparam logic [2:0] ACT_PERSIST = 3'd4;
    localparam logic [2:0] ACT_KEEPPROBE = 3'd5;

    localparam logic [2:0] REG_KEEP_IDLE = 3'd0;
    localparam logic [2:0] REG_KEEP_INTERVAL = 3'd1;
    localparam logic [2:0] REG_MAX_IDLE = 3'd2;
    localparam logic [2:0] REG_RTO_MIN = 3'd3;
    localparam logic [2:0] REG_RTO_MAX = 3'd4;

    typedef struct packed {
        logic [1:0]  timer_kind;
        logic [3:0]  conn_state;
        logic [15:0] idle_ticks;
        logic [3:0]  retx_shift;
        logic [15:0] smoothed_rtt;
        logic [15:0] rtt_variance;
        logic [31:0] send_window;
        logic [31:0] congestion_window;
        logic [15:0] max_segment;
        logic        keepalive_on;
    } t_in;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] timer_reload;
        logic [3:0]  new_retx_shift;
        logic [15:0] new_smoothed_rtt;
        logic [15:0] new_rtt_variance;
        logic [15:0] new_retx_timeout;
        logic [31:0] new_cwnd;
        logic [31:0] new_ssthresh;
        logic        route_losing;
    } t_out;

    typedef struct packed {
        t_out        res;
        logic [31:0] quo_dvd;
        logic [15:0] rem;
        logic [15:0] mss;
        logic        do_ssth;
    } t_work;

    function automatic logic [6:0] backoff_of(input logic [4:0] shift);
        logic [6:0] f;
        case (shift)
            5'd0: f = 7'd1;
            5'd1: f = 7'd2;
            5'd2: f = 7'd4;
            5'd3: f = 7'd8;
            5'd4: f = 7'd16;
            5'd5: f = 7'd32;
            default: f = 7'd64;
        endcase
        return f;
    endfunction

endpackage

// ----- sv/tcp_timer_expiry_action.sv -----
// Top level of the TCP timer expiry action block.
// Depends on tte_pkg.
//
// Usage: one expired timer event enters on the input channel (i_in_valid,
// o_in_stall, i_in_data); one result leaves on the output channel
// (o_out_valid, i_out_stall, o_out_data). A transfer happens at a clock edge
// with valid high and stall low.
// The five registers are written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write them only while no event is in flight, as the block
// does not enforce it. An index beyond the list is ignored. The input
// register feeds one decode stage, eight stages of the ssthresh divider that
// retire four quotient bits each, and the ssthresh multiply into the output
// register. Throughput is one event per cycle unless the receiver stalls.
// When the receiver stalls, the result holds and stages behind it fill up;
// empty stages still advance, so the input keeps taking events until every
// stage holds one.
// Synchronous reset clears all valid bits and loads the register defaults.
module tcp_timer_expiry_action (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tte_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tte_pkg::t_out   o_out_data,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);
    import tte_pkg::*;

    logic [15:0] r_keep_idle, r_keep_interval, r_max_idle, r_rto_min, r_rto_max;

    logic  r_in_v;
    t_in   r_in;
    logic  r_v [0:DIV_STAGES];
    t_work r_w [0:DIV_STAGES];
    logic  r_out_v;
    t_out  r_out;

    logic  rdy [0:DIV_STAGES];
    logic  out_rdy, in_rdy;
    t_work n_w [0:DIV_STAGES];
    t_out  n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_idle <= 16'd14400;
            r_keep_interval <= 16'd150;
            r_max_idle <= 16'd1200;
            r_rto_min <= 16'd2;
            r_rto_max <= 16'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEEP_IDLE: r_keep_idle <= i_cfg_data;
                REG_KEEP_INTERVAL: r_keep_interval <= i_cfg_data;
                REG_MAX_IDLE: r_max_idle <= i_cfg_data;
                REG_RTO_MIN: r_rto_min <= i_cfg_data;
                REG_RTO_MAX: r_rto_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_rdy = !r_out_v || !i_out_stall;
    assign rdy[DIV_STAGES] = !r_v[DIV_STAGES] || out_rdy;
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_rdy
        assign rdy[k] = !r_v[k] || rdy[k+1];
    end
    assign in_rdy = !r_in_v || rdy[0];
    assign o_in_stall = !in_rdy;

    // decode
    always_comb begin
        logic [4:0]  nxt;
        logic [15:0] base;
        logic [22:0] rto;
        logic [16:0] var_sum;
        logic [16:0] keep_lim;
        logic [31:0] win_min;
        t_work w;
        nxt = {1'b0, r_in.retx_shift} + 5'd1;
        base = 16'(({1'b0, r_in.smoothed_rtt >> 2} + {1'b0, r_in.rtt_variance}) >> 1);
        rto = 23'(base * backoff_of(nxt));
        if (rto < {7'd0, r_rto_min}) begin
            rto = {7'd0, r_rto_min};
        end else if (rto > {7'd0, r_rto_max}) begin
            rto = {7'd0, r_rto_max};
        end
        var_sum = {1'b0, r_in.rtt_variance} + {1'b0, r_in.smoothed_rtt >> 2};
        keep_lim = {1'b0, r_keep_idle} + {1'b0, r_max_idle};
        win_min = (r_in.send_window < r_in.congestion_window) ?
                  r_in.send_window : r_in.congestion_window;

        w.res.action = ACT_REARM;
        w.res.timer_reload = '0;
        w.res.new_retx_shift = r_in.retx_shift;
        w.res.new_smoothed_rtt = r_in.smoothed_rtt;
        w.res.new_rtt_variance = r_in.rtt_variance;
        w.res.new_retx_timeout = '0;
        w.res.new_cwnd = r_in.congestion_window;
        w.res.new_ssthresh = '0;
        w.res.route_losing = 1'b0;
        w.quo_dvd = win_min >> 1;
        w.rem = '0;
        w.mss = r_in.max_segment;
        w.do_ssth = 1'b0;

        case (r_in.timer_kind)
            KIND_2MSL: begin
                if (r_in.conn_state != ST_TIME_WAIT && r_in.idle_ticks <= r_max_idle) begin
                    w.res.timer_reload = r_keep_interval;
                end else begin
                    w.res.action = ACT_CLOSE;
                end
            end
            KIND_RETX: begin
                if (nxt > 5'(MAX_SHIFT)) begin
                    w.res.action = ACT_DROP;
                    w.res.new_retx_shift = 4'(MAX_SHIFT);
                end else begin
                    w.res.action = ACT_RETX;
                    w.res.new_retx_shift = nxt[3:0];
                    w.res.new_retx_timeout = rto[15:0];
                    w.res.timer_reload = rto[15:0];
                    if (nxt > 5'(MAX_SHIFT / 4)) begin
                        w.res.route_losing = 1'b1;
                        w.res.new_rtt_variance = var_sum[16] ? 16'hFFFF : var_sum[15:0];
                        w.res.new_smoothed_rtt = '0;
                    end
                    w.res.new_cwnd = {16'd0, r_in.max_segment};
                    w.do_ssth = (r_in.max_segment != 16'd0);
                end
            end
            KIND_PERSIST: begin
                w.res.action = ACT_PERSIST;
            end
            default: begin
                if (r_in.conn_state < ST_ESTABLISHED) begin
                    w.res.action = ACT_DROP;
                end else if (r_in.keepalive_on && r_in.conn_state <= ST_FIN_WAIT_2) begin
                    if ({1'b0, r_in.idle_ticks} >= keep_lim) begin
                        w.res.action = ACT_DROP;
                    end else begin
                        w.res.action = ACT_KEEPPROBE;
                        w.res.timer_reload = r_keep_interval;
                    end
                end else begin
                    w.res.timer_reload = r_keep_idle;
                end
            end
        endcase
        n_w[0] = w;
    end

    // restoring divide, four quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        always_comb begin
            logic [16:0] t;
            t_work w;
            w = r_w[k];
            for (int b = 0; b < DIV_BITS; b++) begin
                t = {w.rem, w.quo_dvd[31]};
                if (t >= {1'b0, w.mss}) begin
                    t = t - {1'b0, w.mss};
                    w.quo_dvd = {w.quo_dvd[30:0], 1'b1};
                end else begin
                    w.quo_dvd = {w.quo_dvd[30:0], 1'b0};
                end
                w.rem = t[15:0];
            end
            n_w[k+1] = w;
        end
    end

    always_comb begin
        logic [31:0] segs;
        logic [47:0] prod;
        segs = (r_w[DIV_STAGES].quo_dvd < 32'd2) ? 32'd2 : r_w[DIV_STAGES].quo_dvd;
        prod = segs * r_w[DIV_STAGES].mss;
        n_out = r_w[DIV_STAGES].res;
        if (r_w[DIV_STAGES].do_ssth) begin
            n_out.new_ssthresh = prod[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            if (in_rdy) begin
                r_in_v <= i_in_valid;
            end
            if (rdy[0]) begin
                r_v[0] <= r_in_v;
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (rdy[k+1]) begin
                    r_v[k+1] <= r_v[k];
                end
            end
            if (out_rdy) begin
                r_out_v <= r_v[DIV_STAGES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy) begin
            r_in <= i_in_data;
        end
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (rdy[k]) begin
                r_w[k] <= n_w[k];
            end
        end
        if (out_rdy) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;

endmodule

// ----- sv/tte_checker.sv -----
// Port checker for the TCP timer expiry action block, bound to its top level.
// Depends on tte_pkg and tcp_timer_expiry_action.
module tte_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input tte_pkg::t_out   o_out_data
);
    import tte_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_retx_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action == ACT_RETX |->
        o_out_data.new_retx_shift != 4'd0 &&
        o_out_data.new_retx_shift <= 4'(MAX_SHIFT) &&
        o_out_data.timer_reload == o_out_data.new_retx_timeout)
        else $error("retransmit result inconsistent");

    a_non_retx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action != ACT_RETX |->
        o_out_data.new_ssthresh == 32'd0 && !o_out_data.route_losing &&
        o_out_data.new_retx_timeout == 16'd0)
        else $error("non-retransmit result touched retransmit fields");

endmodule

bind tcp_timer_expiry_action tte_checker u_tte_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data(o_out_data)
);
